/* rtl/brb_pkg.sv */
`timescale 1ns / 1ps

package brb_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int MAX_READ    = 64;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int LEN_W  = 11;
  localparam int CNT_W  = 7;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_REQ,
    ST_RD_RSP
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/byte_ring_buffer_chunked.sv */
`timescale 1ns / 1ps
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+------------------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready | func, chunk_first, chunk_last, len, byte
// m_axis    | out       | m_axis_tvalid/m_axis_tready | kind, accepted, byte, grant, last, fill
// cfg       | in        | cfg_valid_i/cfg_ready_o     | buffer_size
//
// write and clear words give one result each; a read of n granted bytes goes through
// ST_RD_REQ and ST_RD_RSP for each byte, as the byte store read port is registered (request, then take the data).
// reset empties the ring and sets the size to the full store; store content is not cleared.
// a stalled output holds the result register and with it the input side.

module byte_ring_buffer_chunked import brb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // request_length, data_in
  input  logic [2:0]  s_axis_tuser,   // func, chunk_first
  input  logic        s_axis_tlast,   // chunk_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // data_out, granted_count, fill_level
  output logic [2:0]  m_axis_tuser,   // kind, accepted
  output logic        m_axis_tlast,   // is_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [LEN_W-1:0]  size_q, size_d;
  logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [ADDR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [LEN_W-1:0]  held_q, held_d;
  logic              rej_q, rej_d;

  logic [ADDR_W-1:0] rd_base_q, rd_base_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  grant_q, grant_d;

  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic              out_acc_q, out_acc_d;
  logic [BYTE_W-1:0] out_data_q, out_data_d;
  logic [CNT_W-1:0]  out_grant_q, out_grant_d;
  logic              out_last_q, out_last_d;
  logic [LEN_W-1:0]  out_fill_q, out_fill_d;

  logic              slot_free;
  logic              in_fire, cfg_fire;
  func_e             in_func;
  logic              in_first;
  logic [LEN_W-1:0]  in_len;
  logic [BYTE_W-1:0] in_byte;

  logic              mem_rd_en, rsp_take, rsp_done;
  logic [LEN_W-1:0]  room, g_held, g_room;
  logic [CNT_W-1:0]  grant_w;
  logic              wr_rej, wr_store;
  logic [ADDR_W-1:0] wr_ptr_inc, rd_ptr_adv;
  logic [LEN_W-1:0]  rd_ptr_sum;
  mem_req_t          mem_req;
  logic [BYTE_W-1:0] mem_rdata;

  assign in_func  = func_e'(s_axis_tuser[1:0]);
  assign in_first = s_axis_tuser[2];
  assign in_len   = s_axis_tdata[LEN_W-1:0];
  assign in_byte  = s_axis_tdata[LEN_W+BYTE_W-1:LEN_W];

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign s_axis_tready = (state_q == ST_IDLE) && slot_free && !cfg_valid_i;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;

  // read grant: min of request, fill, bytes to the ring end, max burst
  assign room    = size_q - LEN_W'(rd_ptr_q);
  assign g_held  = (in_len < held_q) ? in_len : held_q;
  assign g_room  = (g_held < room) ? g_held : room;
  assign grant_w = (g_room > LEN_W'(MAX_READ)) ? CNT_W'(MAX_READ) : CNT_W'(g_room);

  assign rd_ptr_sum = LEN_W'(rd_ptr_q) + LEN_W'(grant_w);
  assign rd_ptr_adv = (rd_ptr_sum == size_q) ? '0 : rd_ptr_sum[ADDR_W-1:0];

  // chunk decision is taken on the first byte and kept for the rest
  assign wr_rej     = in_first ? ((size_q - held_q) < in_len) : rej_q;
  assign wr_store   = !wr_rej && (held_q < size_q);
  assign wr_ptr_inc = (LEN_W'(wr_ptr_q) + LEN_W'(1) == size_q) ? '0 : wr_ptr_q + 1'b1;

  assign rsp_done = (idx_q + 1'b1 == grant_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_func == FUNC_READ && grant_w != '0) begin
          state_d = ST_RD_REQ;
        end
      end
      ST_RD_REQ: begin
        state_d = ST_RD_RSP;
      end
      ST_RD_RSP: begin
        if (slot_free) begin
          state_d = rsp_done ? ST_IDLE : ST_RD_REQ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    mem_rd_en = 1'b0;
    rsp_take  = 1'b0;
    case (state_q)
      ST_RD_REQ: mem_rd_en = 1'b1;
      ST_RD_RSP: rsp_take  = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    mem_req.we    = in_fire && in_func == FUNC_WRITE && wr_store;
    mem_req.waddr = wr_ptr_q;
    mem_req.wdata = in_byte;
    mem_req.re    = mem_rd_en;
    mem_req.raddr = rd_base_q + ADDR_W'(idx_q);
  end

  brb_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    size_d      = size_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    held_d      = held_q;
    rej_d       = rej_q;
    rd_base_d   = rd_base_q;
    idx_d       = idx_q;
    grant_d     = grant_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_acc_d   = out_acc_q;
    out_data_d  = out_data_q;
    out_grant_d = out_grant_q;
    out_last_d  = out_last_q;
    out_fill_d  = out_fill_q;

    if (cfg_fire) begin
      if (cfg_data_i == '0) begin
        size_d = LEN_W'(1);
      end else if (cfg_data_i > LEN_W'(STORE_DEPTH)) begin
        size_d = LEN_W'(STORE_DEPTH);
      end else begin
        size_d = cfg_data_i;
      end
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      held_d   = '0;
      rej_d    = 1'b0;
    end

    if (in_fire) begin
      case (in_func)
        FUNC_WRITE: begin
          rej_d = wr_rej;
          if (wr_store) begin
            wr_ptr_d = wr_ptr_inc;
            held_d   = held_q + 1'b1;
          end
          out_valid_d = 1'b1;
          out_kind_d  = KIND_WRITE;
          out_acc_d   = wr_store;
          out_data_d  = '0;
          out_grant_d = '0;
          out_last_d  = s_axis_tlast;
          out_fill_d  = wr_store ? held_q + 1'b1 : held_q;
        end
        FUNC_READ: begin
          rd_base_d = rd_ptr_q;
          idx_d     = '0;
          grant_d   = grant_w;
          if (grant_w == '0) begin
            // empty grant gives one bare result
            out_valid_d = 1'b1;
            out_kind_d  = KIND_READ;
            out_acc_d   = 1'b0;
            out_data_d  = '0;
            out_grant_d = '0;
            out_last_d  = 1'b1;
            out_fill_d  = held_q;
          end else begin
            rd_ptr_d = rd_ptr_adv;
            held_d   = held_q - LEN_W'(grant_w);
          end
        end
        FUNC_CLEAR: begin
          rd_ptr_d    = '0;
          wr_ptr_d    = '0;
          held_d      = '0;
          rej_d       = 1'b0;
          out_valid_d = 1'b1;
          out_kind_d  = KIND_CLEAR;
          out_acc_d   = 1'b0;
          out_data_d  = '0;
          out_grant_d = '0;
          out_last_d  = 1'b1;
          out_fill_d  = '0;
        end
        default: ;
      endcase
    end

    if (rsp_take) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_READ;
      out_acc_d   = 1'b0;
      out_data_d  = mem_rdata;
      out_grant_d = grant_q;
      out_last_d  = rsp_done;
      out_fill_d  = held_q;
      idx_d       = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= LEN_W'(STORE_DEPTH);
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      held_q      <= '0;
      rej_q       <= 1'b0;
      idx_q       <= '0;
      grant_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      held_q      <= held_d;
      rej_q       <= rej_d;
      idx_q       <= idx_d;
      grant_q     <= grant_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_base_q   <= rd_base_d;
    out_kind_q  <= out_kind_d;
    out_acc_q   <= out_acc_d;
    out_data_q  <= out_data_d;
    out_grant_q <= out_grant_d;
    out_last_q  <= out_last_d;
    out_fill_q  <= out_fill_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_fill_q, out_grant_q, out_data_q};
  assign m_axis_tuser  = {out_acc_q, out_kind_q};
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/brb_store.sv */
`timescale 1ns / 1ps

module brb_store import brb_pkg::*; (
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [STORE_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
